>>> src/stbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted table binary search block.
// Used by the controller, the datapath, the top level and the testbench; depends on nothing.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W       = 32;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic miss;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic eq;
        logic cont;
    } t_dp_sts;

endpackage

>>> src/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps
// Top level of the sorted table binary search block.
// Depends on stbs_pkg and instantiates stbs_ctrl and stbs_dp.
//
// Usage:
// The slave stream carries requests. tuser is the command (0 writes one table
// entry, 1 searches); tdata holds entry_index in bits 9:0 and key in 41:10.
// A write request stores key at entry_index and produces no result; an index
// beyond the table is dropped. A search request produces one result on the
// master stream: tuser is found, tdata bits 9:0 the position (0 on a miss).
// The config channel loads entry_count, the number of entries searched from
// index zero; it is always ready and should only be written while idle.
// A write request is stored in the table as it is taken. A search issues the first
// table read, then probes one entry after another (at most log2 of the depth plus
// one probes, 11 for 1024 entries, each bounded by the single synchronous read port
// of the table), and then moves the answer to the output register. A search of an
// empty table skips the probes. A new request is taken once the previous search
// has moved its result out. When the receiver stalls, the result waits in the
// output register and the block may finish one more search before it holds in
// its last state. Reset clears entry_count and the control state; the table
// contents stay undefined until written.
module sorted_table_binary_search_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // Fields from bit 0: entry_index[9:0], key[41:10], zero fill.
    input  logic [stbs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Fields from bit 0: cmd.
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // Fields from bit 0: position[9:0], zero fill.
    output logic [stbs_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Fields from bit 0: found.
    output logic                           o_m_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stbs_pkg::COUNT_W-1:0]   i_cfg_data
);
    import stbs_pkg::*;

    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_dp_cmd   (w_dp_cmd),
        .i_dp_sts   (w_dp_sts)
    );

    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (w_dp_cmd),
        .o_dp_sts      (w_dp_sts),
        .i_entry_index (i_s_tdata[INDEX_W-1:0]),
        .i_key         (i_s_tdata[INDEX_W+KEY_W-1:INDEX_W]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_found       (o_m_tuser),
        .o_m_tdata     (o_m_tdata)
    );

    assign o_cfg_ready = 1'b1;

endmodule

>>> src/stbs_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the sorted table binary search block.
// Depends on stbs_pkg; drives the datapath through command and status structs.
module stbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_cmd,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output stbs_pkg::t_dp_cmd o_dp_cmd,
    input  stbs_pkg::t_dp_sts i_dp_sts
);
    import stbs_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;
    logic    w_accept;

    assign w_accept = i_s_tvalid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_SEARCH) begin
                        if (i_dp_sts.empty) begin
                            w_cmd.miss = 1'b1;
                            n_state    = ST_FINISH;
                        end else begin
                            w_cmd.start = 1'b1;
                            n_state     = ST_SEARCH;
                        end
                    end else begin
                        w_cmd.write = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                w_cmd.step = 1'b1;
                if (i_dp_sts.eq || !i_dp_sts.cont) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_dp_cmd   = w_cmd;

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("Result loaded over an untaken result.");

    a_hit_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) && i_dp_sts.eq |=> (r_state == ST_FINISH))
        else $error("Search continued after a match.");

    a_empty_skips_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_cmd == CMD_SEARCH) && i_dp_sts.empty |=> (r_state == ST_FINISH))
        else $error("Search of an empty table did not finish at once.");

    a_no_search_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !i_dp_sts.empty)
        else $error("Probe issued on an empty table.");

endmodule

>>> src/stbs_dp.sv
`timescale 1ns / 1ps
// Datapath for the sorted table binary search block: table memory, bounds,
// key compare and result registers. Depends on stbs_pkg; driven by stbs_ctrl.
module stbs_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stbs_pkg::t_dp_cmd              i_dp_cmd,
    output stbs_pkg::t_dp_sts              o_dp_sts,
    input  logic [stbs_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [stbs_pkg::KEY_W-1:0]     i_key,
    input  logic                           i_cfg_valid,
    input  logic [stbs_pkg::COUNT_W-1:0]   i_cfg_data,
    output logic                           o_found,
    output logic [stbs_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import stbs_pkg::*;

    logic [KEY_W-1:0]   r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   r_rd_data;
    logic [COUNT_W-1:0] r_entry_count;
    logic [BOUND_W-1:0] r_left;
    logic [BOUND_W-1:0] r_rend;
    logic [ADDR_W-1:0]  r_mid;
    logic [KEY_W-1:0]   r_key;
    logic               r_hit;
    logic [ADDR_W-1:0]  r_pos;
    logic               r_out_found;
    logic [INDEX_W-1:0] r_out_pos;

    logic [BOUND_W-1:0] w_count;
    logic [BOUND_W-1:0] w_mid;
    logic [BOUND_W-1:0] w_mid_inc;
    logic [BOUND_W:0]   w_sum_gt;
    logic [BOUND_W:0]   w_sum_lt;
    logic [ADDR_W-1:0]  w_start_mid;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_eq;
    logic               w_gt;
    logic               w_cont;
    logic               w_rd_en;
    logic               w_done;
    logic               w_wr_ok;

    assign w_count = (32'(r_entry_count) > TABLE_DEPTH) ? BOUND_W'(TABLE_DEPTH)
                                                         : BOUND_W'(r_entry_count);
    assign w_start_mid = ADDR_W'((w_count - 1'b1) >> 1);

    // Both successors of the current probe are prepared in parallel, so the
    // key compare only has to select one of them.
    assign w_mid     = BOUND_W'(r_mid);
    assign w_mid_inc = w_mid + 1'b1;
    assign w_sum_gt  = {1'b0, w_mid} + {1'b0, r_rend};
    assign w_sum_lt  = {1'b0, r_left} + {1'b0, w_mid} - 1'b1;

    assign w_eq   = (r_key == r_rd_data);
    assign w_gt   = ($signed(r_key) > $signed(r_rd_data));
    assign w_cont = w_gt ? (w_mid_inc < r_rend) : (r_left < w_mid);
    assign w_done = w_eq || !w_cont;

    assign w_rd_addr = i_dp_cmd.start ? w_start_mid
                     : w_gt           ? ADDR_W'(w_sum_gt >> 1)
                                      : ADDR_W'(w_sum_lt >> 1);
    assign w_rd_en   = i_dp_cmd.start || (i_dp_cmd.step && !w_done);
    assign w_wr_ok   = (32'(i_entry_index) < TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.write && w_wr_ok) begin
            r_mem[ADDR_W'(i_entry_index)] <= i_key;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_mid <= w_rd_addr;
        end
        if (i_dp_cmd.start) begin
            r_left <= '0;
            r_rend <= w_count;
            r_key  <= i_key;
        end else if (i_dp_cmd.step && !w_done) begin
            if (w_gt) begin
                r_left <= w_mid_inc;
            end else begin
                r_rend <= w_mid;
            end
        end
        if (i_dp_cmd.miss) begin
            r_hit <= 1'b0;
            r_pos <= '0;
        end else if (i_dp_cmd.step && w_done) begin
            r_hit <= w_eq;
            r_pos <= w_eq ? r_mid : '0;
        end
        if (i_dp_cmd.load_out) begin
            r_out_found <= r_hit;
            r_out_pos   <= INDEX_W'(r_pos);
        end
    end

    assign o_dp_sts.empty = (r_entry_count == '0);
    assign o_dp_sts.eq    = w_eq;
    assign o_dp_sts.cont  = w_cont;

    assign o_found   = r_out_found;
    assign o_m_tdata = M_TDATA_W'(r_out_pos);

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_binary_search_top, with its own search predictor.
// Depends on stbs_pkg and the top level; drives directed rows, then randomized table phases.
module tb;
    import stbs_pkg::*;

    localparam int KEY_MIN      = 32'sh8000_0000;
    localparam int KEY_MAX      = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 500;

    typedef enum logic {
        ROW_REQUEST,
        ROW_COUNT
    } t_row_kind;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } t_search_answer;

    typedef struct {
        t_row_kind          kind;
        t_cmd_code          cmd;
        logic [INDEX_W-1:0] index;
        int                 key;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        t_search_answer     answer;
    } t_stim_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    int                   table_copy [TABLE_DEPTH];
    bit                   entry_loaded [TABLE_DEPTH];
    logic [COUNT_W-1:0]   table_count = '0;
    t_search_answer       result_queue [$];
    t_stim_row            stim_rows [$];

    int  gap_pct      = 0;
    int  rx_stall_pct = 0;
    bit  quiet        = 1'b0;
    int  rx_hold      = 0;
    int  error_count  = 0;
    int  request_count = 0;
    int  search_count = 0;
    int  hit_count    = 0;
    int  write_count  = 0;
    int  count_writes = 0;
    int  checked_count = 0;
    int  phase_count  = 0;
    int  stall_cycles = 0;

    sorted_table_binary_search_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_search_answer predict_search(int sought);
        t_search_answer ans;
        int left;
        int right;
        int mid;
        bit done;
        ans = '0;
        done = 1'b0;
        left = 0;
        right = ((table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count)) - 1;
        while (!done && left <= right) begin
            mid = (left + right) / 2;
            if (sought > table_copy[mid]) begin
                left = mid + 1;
            end else if (sought < table_copy[mid]) begin
                right = mid - 1;
            end else begin
                ans.found = 1'b1;
                ans.position = INDEX_W'(mid);
                done = 1'b1;
            end
        end
        return ans;
    endfunction

    task automatic row_request(t_cmd_code cmd, int index, int key, bit typed, bit found, int pos);
        t_stim_row row;
        row.kind = ROW_REQUEST;
        row.cmd = cmd;
        row.index = INDEX_W'(index);
        row.key = key;
        row.count = '0;
        row.typed = typed;
        row.answer.found = found;
        row.answer.position = INDEX_W'(pos);
        stim_rows.push_back(row);
    endtask

    task automatic row_count(int count);
        t_stim_row row;
        row.kind = ROW_COUNT;
        row.cmd = CMD_WRITE;
        row.index = '0;
        row.key = 0;
        row.count = COUNT_W'(count);
        row.typed = 1'b0;
        row.answer = '0;
        stim_rows.push_back(row);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge clk);
        end
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance, once any random sender gap has passed.
    task automatic send_request(t_cmd_code cmd, logic [INDEX_W-1:0] index, int key,
                                bit typed, t_search_answer typed_answer);
        t_search_answer ans;
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {{(S_TDATA_W - KEY_W - INDEX_W){1'b0}}, key, index};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        request_count++;
        if (cmd == CMD_WRITE) begin
            table_copy[index] = key;
            entry_loaded[index] = 1'b1;
            write_count++;
        end else begin
            ans = typed ? typed_answer : predict_search(key);
            result_queue.push_back(ans);
            search_count++;
            if (ans.found) hit_count++;
        end
        @(negedge clk);
        sender_gap();
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (result_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_entry_count(logic [COUNT_W-1:0] count);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data = count;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        table_count = count;
        count_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Loads entries 0..n-1, normally ascending, in a random write order; may also write random entries above n-1.
    task automatic load_table(int n);
        longint v;
        int unsigned step_hi;
        int vals [TABLE_DEPTH];
        int order [TABLE_DEPTH];
        int k;
        int j;
        int t;
        case ($urandom_range(3))
            0: v = KEY_MIN;
            1: v = longint'($signed($urandom()));
            2: v = longint'($urandom_range(200)) - 100;
            default: v = -longint'($urandom_range(1000000));
        endcase
        case ($urandom_range(2))
            0: step_hi = 3;
            1: step_hi = 1000;
            default: step_hi = 32'hFFFF_FFFF / (n + 1);
        endcase
        for (k = 0; k < n; k++) begin
            vals[k] = int'(v);
            v += longint'($urandom_range(step_hi, 0));
            if (v > longint'(KEY_MAX)) v = KEY_MAX;
            order[k] = k;
        end
        if (n > 1 && $urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                j = $urandom_range(n - 1);
                k = $urandom_range(n - 1);
                t = vals[j];
                vals[j] = vals[k];
                vals[k] = t;
            end
        end
        case ($urandom_range(2))
            0: ;
            1: for (k = 0; k < n; k++) order[k] = n - 1 - k;
            default: begin
                for (k = n - 1; k > 0; k--) begin
                    j = $urandom_range(k);
                    t = order[j];
                    order[j] = order[k];
                    order[k] = t;
                end
            end
        endcase
        for (k = 0; k < n; k++) begin
            send_request(CMD_WRITE, INDEX_W'(order[k]), vals[order[k]], 1'b0, '0);
            if (n < TABLE_DEPTH && $urandom_range(9) == 0) begin
                send_request(CMD_WRITE, INDEX_W'($urandom_range(TABLE_DEPTH - 1, n)),
                             $urandom(), 1'b0, '0);
            end
        end
    endtask

    task automatic run_searches(int m);
        int span;
        int pick;
        int key;
        repeat (m) begin
            span = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
            pick = $urandom_range(19);
            if (pick < 10 && span > 0) begin
                key = table_copy[$urandom_range(span - 1)];
            end else if (pick < 14 && span > 0) begin
                key = table_copy[$urandom_range(span - 1)] + (pick[0] ? 1 : -1);
            end else if (pick < 17) begin
                key = $urandom();
            end else begin
                case (pick)
                    17: key = KEY_MIN;
                    18: key = KEY_MAX;
                    default: key = int'($urandom_range(2)) - 1;
                endcase
            end
            send_request(CMD_SEARCH, INDEX_W'($urandom_range(TABLE_DEPTH - 1)), key, 1'b0, '0);
            if ($urandom_range(11) == 0) begin
                send_request(CMD_WRITE, INDEX_W'($urandom_range(TABLE_DEPTH - 1)),
                             $urandom(), 1'b0, '0);
            end
            if (!quiet && $urandom_range(29) == 0) wait_drained();
        end
    endtask

    always @(negedge clk) begin
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (!quiet && $urandom_range(99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_search_answer exp_ans;
        if (rst_n && m_tvalid && m_tready) begin
            if (result_queue.size() == 0) begin
                if (error_count < 20) begin
                    $display("%0t: result with none expected: found=%0b position=%0d",
                             $time, m_tuser, m_tdata[INDEX_W-1:0]);
                end
                error_count++;
            end else begin
                exp_ans = result_queue.pop_front();
                checked_count++;
                if (exp_ans.found !== m_tuser) begin
                    if (error_count < 20) begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, exp_ans.found, m_tuser);
                    end
                    error_count++;
                end
                if (exp_ans.position !== m_tdata[INDEX_W-1:0]) begin
                    if (error_count < 20) begin
                        $display("%0t: position mismatch: expected %0d actual %0d",
                                 $time, exp_ans.position, m_tdata[INDEX_W-1:0]);
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int n;
        int prefix;
        logic [COUNT_W-1:0] c;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // After reset the count is zero, so every search misses.
        row_request(CMD_SEARCH, 0, 0, 1'b1, 1'b0, 0);
        row_request(CMD_SEARCH, 1023, KEY_MIN, 1'b1, 1'b0, 0);
        row_count(0);
        row_request(CMD_SEARCH, 0, KEY_MAX, 1'b1, 1'b0, 0);
        row_request(CMD_WRITE, 0, KEY_MIN, 1'b0, 1'b0, 0);
        row_request(CMD_WRITE, 1, -5, 1'b0, 1'b0, 0);
        row_request(CMD_WRITE, 2, 0, 1'b0, 1'b0, 0);
        row_request(CMD_WRITE, 3, 7, 1'b0, 1'b0, 0);
        row_request(CMD_WRITE, 4, KEY_MAX, 1'b0, 1'b0, 0);
        row_request(CMD_WRITE, 1023, 32'h5A5A_A5A5, 1'b0, 1'b0, 0);
        row_count(5);
        row_request(CMD_SEARCH, 0, KEY_MIN, 1'b1, 1'b1, 0);
        row_request(CMD_SEARCH, 0, KEY_MAX, 1'b1, 1'b1, 4);
        row_request(CMD_SEARCH, 0, 0, 1'b1, 1'b1, 2);
        row_request(CMD_SEARCH, 0, 7, 1'b0, 1'b0, 0);
        row_request(CMD_SEARCH, 0, -5, 1'b0, 1'b0, 0);
        row_request(CMD_SEARCH, 0, 3, 1'b1, 1'b0, 0);
        row_request(CMD_SEARCH, 0, -6, 1'b0, 1'b0, 0);
        row_request(CMD_SEARCH, 0, KEY_MAX - 1, 1'b0, 1'b0, 0);
        row_count(1);
        row_request(CMD_SEARCH, 0, KEY_MIN, 1'b1, 1'b1, 0);
        row_request(CMD_SEARCH, 0, -5, 1'b1, 1'b0, 0);
        // An out-of-order entry makes the search walk past a present key.
        row_request(CMD_WRITE, 2, 100, 1'b0, 1'b0, 0);
        row_count(5);
        row_request(CMD_SEARCH, 0, 7, 1'b0, 1'b0, 0);
        row_request(CMD_SEARCH, 0, 100, 1'b0, 1'b0, 0);

        gap_pct = 20;
        rx_stall_pct = 20;
        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_COUNT) begin
                set_entry_count(stim_rows[r].count);
            end else begin
                send_request(stim_rows[r].cmd, stim_rows[r].index, stim_rows[r].key,
                             stim_rows[r].typed, stim_rows[r].answer);
            end
        end

        // The first phase fills the whole table, so counts at and above the depth are legal
        // from then on.
        while (request_count < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(2))
                0: rx_stall_pct = 0;
                1: rx_stall_pct = 10;
                default: rx_stall_pct = 40;
            endcase
            if (phase_count == 0) begin
                n = TABLE_DEPTH;
            end else begin
                case ($urandom_range(9))
                    0: n = 0;
                    7, 8, 9: n = $urandom_range(60, 25);
                    default: n = $urandom_range(24, 1);
                endcase
            end
            load_table(n);
            prefix = 0;
            while (prefix < TABLE_DEPTH && entry_loaded[prefix]) prefix++;
            if (prefix == TABLE_DEPTH) begin
                case ($urandom_range(5))
                    0: c = COUNT_W'(TABLE_DEPTH);
                    1: c = '1;
                    2: c = COUNT_W'($urandom_range(2047, TABLE_DEPTH + 1));
                    3: c = COUNT_W'($urandom_range(2047));
                    default: c = COUNT_W'(n);
                endcase
            end else begin
                case ($urandom_range(4))
                    0: c = '0;
                    1: c = COUNT_W'($urandom_range(prefix));
                    default: c = COUNT_W'(n);
                endcase
            end
            set_entry_count(c);
            run_searches($urandom_range(40, 12));
            phase_count++;
        end

        quiet = 1'b1;
        gap_pct = 0;
        rx_stall_pct = 0;
        n = $urandom_range(24, 8);
        load_table(n);
        set_entry_count(COUNT_W'(n));
        run_searches(60);
        wait_drained();

        $display("Ran %0d requests over %0d table phases: %0d writes, %0d searches, %0d hits.",
                 request_count, phase_count + 1, write_count, search_count, hit_count);
        $display("Wrote entry_count %0d times and checked %0d results.",
                 count_writes, checked_count);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
